>>> hw/rtl/pksp_pkg.sv
`timescale 1ns / 1ps

package pksp_pkg;

	// Byte values that the parser recognizes or replays.
	localparam logic [7:0] BYTE_PREFIX   = 8'h02;
	localparam logic [7:0] BYTE_ESC      = 8'h1B;
	localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
	localparam logic [7:0] BYTE_UPPER_O  = 8'h4F;

	// Result kinds.
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACTION = 2'd1;
	localparam logic [1:0] KIND_DETACH = 2'd2;

	// Classified item operations carried from the front end to the back end.
	localparam logic [3:0] OP_DATA        = 4'd0; // data byte
	localparam logic [3:0] OP_ACTION      = 4'd1; // pane action
	localparam logic [3:0] OP_DETACH      = 4'd2; // detach request
	localparam logic [3:0] OP_PFX_BYTE    = 4'd3; // 02, byte
	localparam logic [3:0] OP_ESC_BYTE    = 4'd4; // 02, 1B, byte
	localparam logic [3:0] OP_CSI_BYTE    = 4'd5; // 02, 1B, introducer, byte
	localparam logic [3:0] OP_FLUSH_PFX   = 4'd6; // 02
	localparam logic [3:0] OP_FLUSH_ESC   = 4'd7; // 02, 1B
	localparam logic [3:0] OP_FLUSH_CSI   = 4'd8; // 02, 1B, introducer

	// One queued item: operation plus the operands that its results need.
	typedef struct packed {
		logic [3:0] op;
		logic [7:0] data;
		logic [4:0] code;
		logic       intro_o;
	} pksp_entry_t;

endpackage

>>> hw/rtl/pksp_front.sv
`timescale 1ns / 1ps

module pksp_front import pksp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        action_limit,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        in_byte,
	input  logic              chunk_start,
	input  logic              queue_full,
	output logic              push,
	output pksp_entry_t       push_entry
);

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_PREFIX = 2'd1;
	localparam logic [1:0] MODE_ESCAPE = 2'd2;
	localparam logic [1:0] MODE_CSI    = 2'd3;

	typedef struct packed {
		logic       hit;
		logic [4:0] code;
	} pksp_keymap_t;

	// Key map for the byte after the prefix.
	function automatic pksp_keymap_t prefix_code(input logic [7:0] b);
		pksp_keymap_t r;
		r.hit  = 1'b1;
		r.code = 5'd0;
		case (b)
			8'h25: r.code = 5'd0;   // '%'
			8'h22: r.code = 5'd1;   // '"'
			8'h6F: r.code = 5'd6;   // 'o'
			8'h3B: r.code = 5'd7;   // ';'
			8'h78: r.code = 5'd8;   // 'x'
			8'h7A: r.code = 5'd9;   // 'z'
			8'h63: r.code = 5'd10;  // 'c'
			8'h6E: r.code = 5'd11;  // 'n'
			8'h70: r.code = 5'd12;  // 'p'
			8'h26: r.code = 5'd13;  // '&'
			default: begin
				if (b >= 8'h30 && b <= 8'h39) begin
					r.code = 5'd14 + {1'b0, b[3:0]};
				end else begin
					r.hit = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	// Arrow letters after ESC [ or ESC O.
	function automatic pksp_keymap_t arrow_code(input logic [7:0] b);
		pksp_keymap_t r;
		r.hit  = 1'b1;
		r.code = 5'd0;
		case (b)
			8'h44: r.code = 5'd2;   // 'D'
			8'h43: r.code = 5'd3;   // 'C'
			8'h41: r.code = 5'd4;   // 'A'
			8'h42: r.code = 5'd5;   // 'B'
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	logic [1:0]   mode_q, mode_d;
	logic         intro_o_q, intro_o_d;
	logic [7:0]   actions_q, actions_d;
	logic         discard_q, discard_d;
	logic         emit;
	logic         in_fire;
	pksp_keymap_t pmap, amap;

	assign in_ready = !queue_full;
	assign in_fire  = in_valid && in_ready;
	assign push     = in_fire && emit;
	assign pmap     = prefix_code(in_byte);
	assign amap     = arrow_code(in_byte);

	// Classify the item against the current mode and work out the next state.
	always_comb begin
		mode_d     = mode_q;
		intro_o_d  = intro_o_q;
		actions_d  = actions_q;
		discard_d  = discard_q;
		emit       = 1'b0;
		push_entry.op      = OP_DATA;
		push_entry.data    = in_byte;
		push_entry.code    = 5'd0;
		push_entry.intro_o = intro_o_q;
		if (req_type) begin
			// Flush replays whatever partial sequence is pending.
			mode_d = MODE_NORMAL;
			case (mode_q)
				MODE_PREFIX: begin
					emit = 1'b1;
					push_entry.op = OP_FLUSH_PFX;
				end
				MODE_ESCAPE: begin
					emit = 1'b1;
					push_entry.op = OP_FLUSH_ESC;
				end
				MODE_CSI: begin
					emit = 1'b1;
					push_entry.op = OP_FLUSH_CSI;
				end
				default: emit = 1'b0;
			endcase
		end else begin
			if (chunk_start) begin
				actions_d = 8'd0;
				discard_d = 1'b0;
			end
			if (!discard_d) begin
				case (mode_q)
					MODE_NORMAL: begin
						if (in_byte == BYTE_PREFIX) begin
							mode_d = MODE_PREFIX;
						end else begin
							emit = 1'b1;
							push_entry.op = OP_DATA;
						end
					end
					MODE_ESCAPE: begin
						if (in_byte == BYTE_LBRACKET || in_byte == BYTE_UPPER_O) begin
							intro_o_d = (in_byte == BYTE_UPPER_O);
							mode_d    = MODE_CSI;
						end else begin
							emit = 1'b1;
							push_entry.op = OP_ESC_BYTE;
							mode_d = MODE_NORMAL;
						end
					end
					MODE_CSI: begin
						emit   = 1'b1;
						mode_d = MODE_NORMAL;
						if (amap.hit && actions_d < action_limit) begin
							actions_d = actions_d + 8'd1;
							push_entry.op   = OP_ACTION;
							push_entry.code = amap.code;
						end else begin
							push_entry.op = OP_CSI_BYTE;
						end
					end
					default: begin
						mode_d = MODE_NORMAL;
						if (in_byte == 8'h64) begin
							// 'd' detaches and drops the rest of the chunk.
							emit = 1'b1;
							push_entry.op = OP_DETACH;
							discard_d = 1'b1;
						end else if (in_byte == BYTE_PREFIX) begin
							emit = 1'b1;
							push_entry.op = OP_DATA;
						end else if (in_byte == BYTE_ESC) begin
							mode_d = MODE_ESCAPE;
						end else if (pmap.hit && actions_d < action_limit) begin
							emit = 1'b1;
							actions_d = actions_d + 8'd1;
							push_entry.op   = OP_ACTION;
							push_entry.code = pmap.code;
						end else begin
							emit = 1'b1;
							push_entry.op = OP_PFX_BYTE;
						end
					end
				endcase
			end
		end
	end

	// Parser state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			intro_o_q <= 1'b0;
			actions_q <= 8'd0;
			discard_q <= 1'b0;
		end else if (in_fire) begin
			mode_q    <= mode_d;
			intro_o_q <= intro_o_d;
			actions_q <= actions_d;
			discard_q <= discard_d;
		end
	end

endmodule

>>> hw/rtl/pksp_queue.sv
`timescale 1ns / 1ps

module pksp_queue import pksp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pksp_entry_t push_entry,
	input  logic        pop,
	output logic        full,
	output logic        head_valid,
	output pksp_entry_t head_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	pksp_entry_t   slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/pksp_back.sv
`timescale 1ns / 1ps

module pksp_back import pksp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  pksp_entry_t head_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [4:0]  action_code,
	output logic        last_of_run
);

	// Index of the last result that an operation yields.
	function automatic logic [1:0] last_index(input logic [3:0] op);
		logic [1:0] r;
		case (op)
			OP_PFX_BYTE:  r = 2'd1;
			OP_ESC_BYTE:  r = 2'd2;
			OP_CSI_BYTE:  r = 2'd3;
			OP_FLUSH_ESC: r = 2'd1;
			OP_FLUSH_CSI: r = 2'd2;
			default:      r = 2'd0;
		endcase
		return r;
	endfunction

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       load;
	logic       is_last;
	logic [1:0] kind_c;
	logic [7:0] byte_c;
	logic [4:0] code_c;
	logic [7:0] intro_byte;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [4:0] code_q;
	logic       last_q;

	assign last_idx   = last_index(head_entry.op);
	assign is_last    = (idx_q == last_idx);
	assign load       = head_valid && (!out_valid_q || out_ready);
	assign pop        = load && is_last;
	assign intro_byte = head_entry.intro_o ? BYTE_UPPER_O : BYTE_LBRACKET;

	// Pick the result at the current index of the head item.
	always_comb begin
		kind_c = KIND_DATA;
		code_c = 5'd0;
		byte_c = 8'd0;
		case (head_entry.op)
			OP_ACTION: begin
				kind_c = KIND_ACTION;
				code_c = head_entry.code;
			end
			OP_DETACH: kind_c = KIND_DETACH;
			OP_DATA:   byte_c = head_entry.data;
			default: begin
				// Replayed literals: prefix, ESC, introducer, then the byte itself.
				case (idx_q)
					2'd0: byte_c = BYTE_PREFIX;
					2'd1: byte_c = (head_entry.op == OP_PFX_BYTE) ? head_entry.data : BYTE_ESC;
					2'd2: byte_c = (head_entry.op == OP_ESC_BYTE) ? head_entry.data : intro_byte;
					default: byte_c = head_entry.data;
				endcase
			end
		endcase
	end

	// Result index within the head item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_c;
			byte_q <= byte_c;
			code_q <= code_c;
			last_q <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = kind_q;
	assign out_byte    = byte_q;
	assign action_code = code_q;
	assign last_of_run = last_q;

endmodule

>>> hw/rtl/prefix_key_stream_parser.sv
`timescale 1ns / 1ps
// Accepts one item per cycle while the item queue has room; delivers one result per cycle
// while out_ready is high and items are queued; results leave from a registered output.
// An item that replays literals yields one to four results, and the QUEUE_DEPTH-entry item
// queue absorbs those bursts; the result stage sets the output rate.
// Reset (arst_n low, asynchronous): normal mode, counters and queue cleared, limit back to 16.

module prefix_key_stream_parser import pksp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  in_byte,
	input  logic        chunk_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [4:0]  action_code,
	output logic        last_of_run
);

	logic [7:0]  action_limit_q;
	logic        cfg_write;
	logic        queue_full;
	logic        push;
	logic        pop;
	logic        head_valid;
	pksp_entry_t push_entry;
	pksp_entry_t head_entry;

	// Register port: action_limit at byte address 0.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata    = (paddr[2] == 1'b0) ? {24'd0, action_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_limit_q <= 8'd16;
		end else if (cfg_write) begin
			action_limit_q <= pwdata[7:0];
		end
	end

	pksp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.action_limit (action_limit_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.in_byte      (in_byte),
		.chunk_start  (chunk_start),
		.queue_full   (queue_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	pksp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	pksp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_entry  (head_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.action_code (action_code),
		.last_of_run (last_of_run)
	);

endmodule
